// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the interpolation stepper.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ilis_pkg.sv =====
// Package for the integer linear interpolation stepper: shared constants and types.
// Depends on nothing; used by the interfaces, the divider and the top level.
package ilis_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int VALUE_BITS     = 32;

    // Function codes of a command word.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Status of the shared serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/ilis_if.sv =====
// Valid/ready channels of the interpolation stepper: command words in, result words out.
// Depends on ilis_pkg.
interface ilis_cmd_if #(
    parameter int COORD_BITS = ilis_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] span_start;
    logic signed [COORD_BITS-1:0] first_pos;
    logic signed [COORD_BITS-1:0] span_end;
    logic signed [COORD_BITS-1:0] value_start;
    logic signed [COORD_BITS-1:0] value_end;

    modport source (
        output valid, func, span_start, first_pos, span_end, value_start, value_end,
        input  ready
    );
    modport sink (
        input  valid, func, span_start, first_pos, span_end, value_start, value_end,
        output ready
    );
endinterface

interface ilis_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ilis_pkg::VALUE_BITS-1:0]  value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

// ===== rtl/ilis_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, for the interpolation stepper.
// Depends on ilis_pkg (div_stat_t).
module ilis_div #(
    parameter int DW = 35,
    parameter int VW = 17,
    parameter int CW = $clog2(DW + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CW-1:0]       nbits,
    input  logic [DW-1:0]       dividend,
    input  logic [VW-1:0]       divisor,
    output ilis_pkg::div_stat_t stat,
    output logic [DW-1:0]       quot,
    output logic [VW-1:0]       rem
);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW+1:0] trial;
    logic          fits;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {1'b0, rem_reg, quo_reg[DW-1]} - {2'b0, dvs_reg};
    assign fits  = ~trial[VW+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? trial[VW-1:0] : {rem_reg[VW-2:0], quo_reg[DW-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;
    assign rem       = rem_reg;

endmodule

// ===== rtl/integer_linear_interpolation_stepper_top.sv =====
// Integer linear interpolation stepper, top level. N = COORD_BITS.
// Start word: after acceptance, busy through a shift-add multiply over N+2 multiplier bits,
//   the divider load, a serial divide of 2N+3 quotient bits and completion; no result.
// Step word: result without a divide when there is no carry, after a serial divide of N+2
//   quotient bits when the remainder reaches the span length; one word in flight at a time.
// Reset (rst_n, async, active low): value, remainder and span state cleared, channels idle.
`include "assert_macros.svh"

module integer_linear_interpolation_stepper_top #(
    parameter int COORD_BITS = ilis_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ilis_cmd_if.sink  cmd,
    ilis_res_if.source res
);

    localparam int N  = COORD_BITS;
    localparam int VB = ilis_pkg::VALUE_BITS;
    localparam int PW = 2 * N + 3;          // |offset| * |value delta|
    localparam int VW = N + 1;              // span length, value delta
    localparam int RW = N + 4;              // running remainder
    localparam int CW = $clog2(PW + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHK   = 6'b000010,
        S_MUL   = 6'b000100,
        S_LDIV  = 6'b001000,
        S_DIV   = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic          is_step_reg, is_step_next;
    logic [VB-1:0] value_reg, value_next;
    logic          sign_reg, sign_next;
    logic [VW-1:0] vdelta_reg, vdelta_next;
    logic [VW-1:0] slen_reg, slen_next;
    logic [RW-1:0] srem_reg, srem_next;
    logic [N-1:0]  dval_reg, dval_next;
    logic          qneg_reg, qneg_next;
    logic          offneg_reg, offneg_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [N+1:0]  mplier_reg, mplier_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VB-1:0] rslt_reg, rslt_next;
    logic [VB-1:0] oval_reg, oval_next;
    logic          ovalid_reg, ovalid_next;

    // Span geometry of the incoming word.
    logic [N+1:0]  off;
    logic [N+1:0]  aoff;
    logic [N:0]    dv, dp, adv, adp;

    // Shared divider.
    logic                div_start;
    logic [CW-1:0]       div_nbits;
    logic [PW-1:0]       div_dividend;
    logic [VW-1:0]       div_divisor;
    ilis_pkg::div_stat_t div_stat;
    logic [PW-1:0]       div_quot;
    logic [VW-1:0]       div_rem;
    logic [PW+VB-1:0]    quot_ext;
    logic [VB-1:0]       q32;
    logic [VB-1:0]       dext;
    logic                carry_due;

    // offset = b - 1 - a, value delta = f - d, span delta = c - a, then magnitudes.
    assign off  = {{2{cmd.first_pos[N-1]}}, cmd.first_pos}
                - {{2{cmd.span_start[N-1]}}, cmd.span_start} - (N+2)'(1);
    assign dv   = {cmd.value_end[N-1], cmd.value_end} - {cmd.value_start[N-1], cmd.value_start};
    assign dp   = {cmd.span_end[N-1], cmd.span_end} - {cmd.span_start[N-1], cmd.span_start};
    assign aoff = off[N+1] ? -off : off;
    assign adv  = dv[N] ? -dv : dv;
    assign adp  = dp[N] ? -dp : dp;

    // Low 32 bits of the quotient, whether it is wider or narrower than 32.
    assign quot_ext = {{VB{1'b0}}, div_quot};
    assign q32      = quot_ext[VB-1:0];
    assign dext     = {{(VB-N){dval_reg[N-1]}}, dval_reg};

    // A step carries when the remainder has reached the span length.
    assign carry_due = $signed(srem_reg) >= $signed({3'b000, slen_reg});

    assign div_start    = (state_reg == S_LDIV)
                       || ((state_reg == S_CHK) && (slen_reg != '0) && carry_due);
    assign div_nbits    = is_step_reg ? CW'(N + 2) : CW'(PW);
    assign div_dividend = is_step_reg ? {srem_reg[N+1:0], {(N+1){1'b0}}} : acc_reg;
    assign div_divisor  = (slen_reg == '0) ? VW'(1) : slen_reg;

    ilis_div #(
        .DW (PW),
        .VW (VW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .nbits    (div_nbits),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        is_step_next = is_step_reg;
        value_next   = value_reg;
        sign_next    = sign_reg;
        vdelta_next  = vdelta_reg;
        slen_next    = slen_reg;
        srem_next    = srem_reg;
        dval_next    = dval_reg;
        qneg_next    = qneg_reg;
        offneg_next  = offneg_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        rslt_next    = rslt_reg;
        oval_next    = oval_reg;
        ovalid_next  = ovalid_reg;

        // Drop the output word once the sink takes it.
        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.func == ilis_pkg::FUNC_START)
                    begin
                        // Load span state and arm the shift-add multiplier.
                        mcand_next   = {{(PW-N-1){1'b0}}, adv};
                        mplier_next  = aoff;
                        acc_next     = '0;
                        cnt_next     = CW'(N + 2);
                        slen_next    = adp;
                        vdelta_next  = adv;
                        sign_next    = dv[N] ^ dp[N];
                        qneg_next    = off[N+1] ^ dv[N] ^ dp[N];
                        offneg_next  = off[N+1];
                        dval_next    = cmd.value_start;
                        is_step_next = 1'b0;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        // Advance the position: accumulate the value delta.
                        srem_next    = srem_reg + {3'b000, vdelta_reg};
                        is_step_next = 1'b1;
                        state_next   = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (slen_reg == '0)
                begin
                    rslt_next  = '0;
                    state_next = S_WRITE;
                end
                else if (carry_due)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    rslt_next  = value_reg;
                    state_next = S_WRITE;
                end
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[N+1:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_LDIV;
                end
            end
            S_LDIV:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (is_step_reg)
                    begin
                        // Take all whole span lengths out of the remainder at once.
                        value_next = sign_reg ? value_reg - q32 : value_reg + q32;
                        rslt_next  = sign_reg ? value_reg - q32 : value_reg + q32;
                        srem_next  = {3'b000, div_rem};
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        // Signed quotient plus the start value; remainder follows the offset.
                        value_next = dext + (qneg_reg ? -q32 : q32);
                        srem_next  = offneg_reg ? -{3'b000, div_rem} : {3'b000, div_rem};
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                // Hold the result until the output register is free.
                if (!ovalid_reg || res.ready)
                begin
                    oval_next   = rslt_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_step_reg <= 1'b0;
            value_reg   <= '0;
            sign_reg    <= 1'b0;
            vdelta_reg  <= '0;
            slen_reg    <= '0;
            srem_reg    <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_step_reg <= is_step_next;
            value_reg   <= value_next;
            sign_reg    <= sign_next;
            vdelta_reg  <= vdelta_next;
            slen_reg    <= slen_next;
            srem_reg    <= srem_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dval_reg   <= dval_next;
        qneg_reg   <= qneg_next;
        offneg_reg <= offneg_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rslt_reg   <= rslt_next;
        oval_reg   <= oval_next;
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = ovalid_reg;
    assign res.value = oval_reg;

    `ASSERT_SAME(a_ready_div_idle, cmd.ready, !div_stat.busy && !div_stat.done,
                 "divider active while accepting a word")
    `ASSERT_SAME(a_done_in_div, div_stat.done, state_reg == S_DIV,
                 "divider finished outside the divide state")
    `ASSERT_NEXT(a_start_no_result,
                 cmd.valid && cmd.ready && (cmd.func == ilis_pkg::FUNC_START),
                 state_reg == S_MUL, "start word did not enter the multiply")
    `ASSERT_NEXT(a_write_loads, (state_reg == S_WRITE) && (!ovalid_reg || res.ready),
                 ovalid_reg && (state_reg == S_IDLE), "pending result not loaded")

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the integer linear interpolation stepper: drives command words, predicts
// and checks every result word. Depends on ilis_pkg, ilis_cmd_if/ilis_res_if and the
// integer_linear_interpolation_stepper_top RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB             = ilis_pkg::COORD_BITS_DEF;
    localparam int VB             = ilis_pkg::VALUE_BITS;
    localparam int MAG_W          = CB + 1;
    localparam int REM_W          = CB + 4;
    localparam int LONG_HOLD      = 300;   // receiver hold-off that fills the block
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 100;   // well above the slowest start word
    localparam int PHASE_WORDS    = 280;   // random words per idling phase

    // One command word as the sender sees it.
    typedef struct {
        logic                 func;
        logic signed [CB-1:0] span_start;
        logic signed [CB-1:0] first_pos;
        logic signed [CB-1:0] span_end;
        logic signed [CB-1:0] value_start;
        logic signed [CB-1:0] value_end;
    } cmd_word_t;

    // Tracks the interpolator state and the queue of values it must return.
    class interp_scoreboard;
        logic [VB-1:0]           cur_value;
        bit                      step_minus;
        logic [MAG_W-1:0]        delta_abs;
        logic [MAG_W-1:0]        span_abs;
        logic signed [REM_W-1:0] carry_acc;
        logic signed [VB-1:0]    expected_values[$];
        int                      errors;

        function new();
            cur_value  = '0;
            step_minus = 1'b0;
            delta_abs  = '0;
            span_abs   = '0;
            carry_acc  = '0;
            errors     = 0;
        endfunction

        function void note_word(cmd_word_t w);
            longint a, b, c, d, f, off, dv, dp, adv, adp, q, acc, k;
            if (w.func == ilis_pkg::FUNC_START)
            begin
                a   = longint'(w.span_start);
                b   = longint'(w.first_pos);
                c   = longint'(w.span_end);
                d   = longint'(w.value_start);
                f   = longint'(w.value_end);
                off = b - 1 - a;
                dv  = f - d;
                dp  = c - a;
                adv = (dv < 0) ? -dv : dv;
                adp = (dp < 0) ? -dp : dp;
                // Division truncates toward zero; a zero span divides by one.
                q   = (off * dv) / ((dp != 0) ? dp : longint'(1));
                cur_value  = VB'(d + q);
                step_minus = ((f < d) != (c < a));
                delta_abs  = MAG_W'(adv);
                span_abs   = MAG_W'(adp);
                // Remainder keeps the sign of the dividend.
                carry_acc  = REM_W'((adp != 0) ? (off * adv) % adp : longint'(0));
            end
            else
            begin
                acc       = longint'(carry_acc) + longint'(delta_abs);
                carry_acc = REM_W'(acc);
                if (span_abs == 0)
                begin
                    expected_values.push_back('0);
                end
                else
                begin
                    if (longint'(carry_acc) >= longint'(span_abs))
                    begin
                        // Take every whole span out at once.
                        k = longint'(carry_acc) / longint'(span_abs);
                        if (step_minus)
                            cur_value = cur_value - k[VB-1:0];
                        else
                            cur_value = cur_value + k[VB-1:0];
                        carry_acc = REM_W'(longint'(carry_acc) - k * longint'(span_abs));
                    end
                    expected_values.push_back(cur_value);
                end
            end
        endfunction

        function void check_value(logic signed [VB-1:0] got);
            logic signed [VB-1:0] exp_value;
            if (expected_values.size() == 0)
            begin
                $error("value: expected none, actual %0d", got);
                errors++;
            end
            else
            begin
                exp_value = expected_values.pop_front();
                if (got !== exp_value)
                begin
                    $error("value: expected %0d, actual %0d", exp_value, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ilis_cmd_if #(.COORD_BITS(CB)) cmd();
    ilis_res_if                    res();

    integer_linear_interpolation_stepper_top #(.COORD_BITS(CB)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    interp_scoreboard sb;

    int src_idle_pct;   // sender idle chance, percent
    int snk_idle_pct;   // receiver idle chance, percent
    int stall_req;      // bump to ask the receiver for one long hold-off
    int stall_seen;
    int hold_left;
    int quiet_cycles;
    int words_sent;

    // Free-running 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: drop ready at random, or hold it low for a long stretch on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_req != stall_seen)
        begin
            res.ready  <= 1'b0;
            stall_seen <= stall_req;
            hold_left  <= LONG_HOLD;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Check every result word the moment it is handed over.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_value(res.value);
    end

    // Watchdog: count cycles without any handshake and end a hung run.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cmd_word_t make_start(int a, int b, int c, int d, int f);
        cmd_word_t w;
        w.func        = ilis_pkg::FUNC_START;
        w.span_start  = CB'(a);
        w.first_pos   = CB'(b);
        w.span_end    = CB'(c);
        w.value_start = CB'(d);
        w.value_end   = CB'(f);
        return w;
    endfunction

    // Step words ignore the position fields; fill them with noise anyway.
    function automatic cmd_word_t make_step();
        cmd_word_t w;
        w.func        = ilis_pkg::FUNC_STEP;
        w.span_start  = CB'($urandom);
        w.first_pos   = CB'($urandom);
        w.span_end    = CB'($urandom);
        w.value_start = CB'($urandom);
        w.value_end   = CB'($urandom);
        return w;
    endfunction

    // Random span, biased toward shapes that exercise the carry logic.
    function automatic cmd_word_t rand_start();
        int a, c, d, f, b;
        a = $urandom;
        d = $urandom;
        case ($urandom_range(3))
            0:
            begin
                c = $urandom;
                f = $urandom;
                b = $urandom;
            end
            1:
            begin
                // short span, possibly empty
                c = a + $urandom_range(80) - 40;
                f = d + $urandom_range(400) - 200;
                b = a + $urandom_range(24) - 4;
            end
            2:
            begin
                // tiny span, large swing: many carries per step
                c = a + (($urandom_range(1)) ? 1 : -1) * $urandom_range(1, 3);
                f = $urandom;
                b = a + $urandom_range(40) - 8;
            end
            default:
            begin
                // long span, small swing: rare carries
                c = $urandom;
                f = d + $urandom_range(16) - 8;
                b = a + $urandom_range(60) - 10;
            end
        endcase
        return make_start(a, b, c, d, f);
    endfunction

    // Offer one word, idling first at random; hold valid high across back-to-back words.
    task automatic send_word(cmd_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.func        <= w.func;
        cmd.span_start  <= w.span_start;
        cmd.first_pos   <= w.first_pos;
        cmd.span_end    <= w.span_end;
        cmd.value_start <= w.value_start;
        cmd.value_end   <= w.value_end;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_steps(int n);
        repeat (n) send_word(make_step());
    endtask

    // Random part: mostly start-plus-steps sequences, some loose noise words.
    task automatic run_random(int until_words);
        cmd_word_t w;
        while (words_sent < until_words)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_word(rand_start());
                send_steps($urandom_range(1, 24));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    w = make_step();
                    if ($urandom_range(1))
                        w = rand_start();
                    send_word(w);
                end
            end
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        src_idle_pct = 29;
        snk_idle_pct = 64;
        stall_req    = 0;
        words_sent   = 0;
        cmd.valid       = 1'b0;
        cmd.func        = ilis_pkg::FUNC_START;
        cmd.span_start  = '0;
        cmd.first_pos   = '0;
        cmd.span_end    = '0;
        cmd.value_start = '0;
        cmd.value_end   = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Step before any span is loaded: state is at reset, so the value is zero.
        send_word(make_step());

        // Empty span: the value stays zero however many steps follow.
        send_word(make_start(5, 9, 5, -100, 300));
        send_steps(2);

        // Widest span and widest swing, starting one before the span.
        send_word(make_start(-32768, -32768, 32767, -32768, 32767));
        send_steps(2);

        // Unit span with full swing: the start value wraps past 32 bits and
        // every step carries many units at once, downward.
        send_word(make_start(-32768, 32767, -32767, 32767, -32768));
        send_steps(3);

        // First position behind the span start: remainder starts negative.
        send_word(make_start(100, 50, 107, 0, 20));
        send_steps(3);

        // Span runs backward while the value rises: step sign is minus.
        send_word(make_start(1000, 990, 900, -5, 40));
        send_steps(2);

        // Both span and value run backward: step sign is plus again.
        send_word(make_start(32767, 32767, -32768, 32767, -32768));
        send_steps(2);

        // Sender idles lightly, receiver heavily.
        run_random(words_sent + PHASE_WORDS);

        // Swap the idling.
        src_idle_pct = 64;
        snk_idle_pct <= 29;
        run_random(words_sent + PHASE_WORDS);

        // No idling; open with a long receiver hold-off so the input backs up.
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        stall_req    <= stall_req + 1;
        run_random(words_sent + PHASE_WORDS);

        cmd.valid <= 1'b0;

        // Drain: wait for every expected value, then let the block settle.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ilis_pkg.sv
rtl/ilis_if.sv
rtl/ilis_div.sv
rtl/integer_linear_interpolation_stepper_top.sv
tb/tb_top.sv
